>>> rtl/jse_pkg.sv
// Shared types, constants and character helpers for the JSON string escaper.
// Used by jse_front, jse_queue, jse_back and json_string_escaper.
// No dependencies.
package jse_pkg;

    // Default depth of the job queue between the front and back parts.
    localparam int JSE_QUEUE_DEPTH = 2;

    // Position of the final character of a six-character escape.
    localparam logic [2:0] JSE_ESC_LAST_POS = 3'd5;

    // Characters used when building escapes.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_D  = 8'h64;

    // Byte sequence of up to six characters, element i is sent i-th.
    typedef struct packed {
        logic [2:0]      len;
        logic [5:0][7:0] bytes;
    } jse_seq_t;

    // One job for the back part: a number of replacement-character escapes
    // followed by a tail of up to six literal bytes.
    typedef struct packed {
        logic [2:0]      esc_cnt;
        logic [2:0]      tail_len;
        logic [5:0][7:0] tail;
        logic            last;
    } jse_job_t;

    // Lowercase hex digit for a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] wide;
        wide = {4'h0, n};
        if (n < 4'd10) begin
            return CH_ZERO + wide;
        end
        return 8'h57 + wide;
    endfunction

    // Character at a given position of the replacement-character escape.
    function automatic logic [7:0] fffd_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0: ch = CH_BSLASH;
            3'd1: ch = CH_LOW_U;
            3'd2: ch = CH_LOW_F;
            3'd3: ch = CH_LOW_F;
            3'd4: ch = CH_LOW_F;
            3'd5: ch = CH_LOW_D;
            default: ch = CH_BSLASH;
        endcase
        return ch;
    endfunction

    // Escaped form of a byte that is neither a lead nor part of a sequence.
    function automatic jse_seq_t single_seq(input logic [7:0] c);
        jse_seq_t s;
        s.len   = 3'd2;
        s.bytes = '0;
        s.bytes[0] = CH_BSLASH;
        case (c)
            CH_QUOTE:  s.bytes[1] = CH_QUOTE;
            CH_BSLASH: s.bytes[1] = CH_BSLASH;
            CH_LF:     s.bytes[1] = CH_LOW_N;
            CH_CR:     s.bytes[1] = CH_LOW_R;
            CH_TAB:    s.bytes[1] = CH_LOW_T;
            CH_BS:     s.bytes[1] = CH_LOW_B;
            CH_FF:     s.bytes[1] = CH_LOW_F;
            default: begin
                if (c < 8'h20 || c == CH_DEL) begin
                    s.len      = 3'd6;
                    s.bytes[1] = CH_LOW_U;
                    s.bytes[2] = CH_ZERO;
                    s.bytes[3] = CH_ZERO;
                    s.bytes[4] = hex_char(c[7:4]);
                    s.bytes[5] = hex_char(c[3:0]);
                end else if (c < 8'h80) begin
                    s.len      = 3'd1;
                    s.bytes[0] = c;
                end else begin
                    s.len = 3'd6;
                    for (int i = 0; i < 6; i++) begin
                        s.bytes[i] = fffd_char(3'(i));
                    end
                end
            end
        endcase
        return s;
    endfunction

endpackage

>>> rtl/jse_front.sv
// Front part of the JSON string escaper: tracks held UTF-8 sequences and turns
// each accepted byte into a job for the back part.
// Depends on jse_pkg.
module jse_front
    import jse_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       push,
    output jse_job_t   job
);

    logic [7:0] held_reg [0:2];
    logic [1:0] held_count_reg, held_count_next;
    logic [1:0] needed_reg, needed_next;
    logic       wr_en;
    logic [1:0] wr_idx;
    logic       is_cont, is_lead;
    jse_seq_t   single;
    logic [5:0][7:0] raw;

    // Classify the byte and work out the job and the next hold state.
    always_comb begin
        is_cont = (in_byte[7:6] == 2'b10);
        is_lead = (in_byte[7:6] == 2'b11);
        single  = single_seq(in_byte);

        for (int i = 0; i < 3; i++) begin
            raw[i] = (2'(i) < held_count_reg) ? held_reg[i] : in_byte;
        end
        raw[3] = in_byte;
        raw[4] = in_byte;
        raw[5] = in_byte;

        job.esc_cnt  = 3'd0;
        job.tail_len = 3'd0;
        job.tail     = single.bytes;
        job.last     = in_last;
        held_count_next = held_count_reg;
        needed_next     = needed_reg;
        wr_en  = 1'b0;
        wr_idx = held_count_reg;

        if (held_count_reg != 2'd0 && is_cont) begin
            if (needed_reg <= 2'd1) begin
                // Sequence complete: pass all of it through unchanged.
                job.tail        = raw;
                job.tail_len    = {1'b0, held_count_reg} + 3'd1;
                held_count_next = 2'd0;
                needed_next     = 2'd0;
            end else begin
                wr_en           = 1'b1;
                held_count_next = held_count_reg + 2'd1;
                needed_next     = needed_reg - 2'd1;
            end
        end else begin
            // Anything held is broken: one replacement escape per held byte.
            job.esc_cnt = {1'b0, held_count_reg};
            if (is_lead) begin
                wr_en           = 1'b1;
                wr_idx          = 2'd0;
                held_count_next = 2'd1;
                needed_next     = (in_byte >= 8'hF0) ? 2'd3 :
                                  (in_byte >= 8'hE0) ? 2'd2 : 2'd1;
            end else begin
                job.tail_len    = single.len;
                held_count_next = 2'd0;
                needed_next     = 2'd0;
            end
        end

        // End of string with an incomplete sequence: flush it.
        if (in_last && held_count_next != 2'd0) begin
            job.esc_cnt     = job.esc_cnt + {1'b0, held_count_next};
            held_count_next = 2'd0;
            needed_next     = 2'd0;
        end

        push = accept && (job.esc_cnt != 3'd0 || job.tail_len != 3'd0);
    end

    // Hold state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= 2'd0;
            needed_reg     <= 2'd0;
        end else if (accept) begin
            held_count_reg <= held_count_next;
            needed_reg     <= needed_next;
        end
    end

    // Held bytes need no reset: only entries below the count are read.
    always_ff @(posedge aclk) begin
        if (accept && wr_en) begin
            held_reg[wr_idx] <= in_byte;
        end
    end

`ifndef ASSERT_OFF
    // A held sequence always still expects at least one continuation.
    a_held_needs: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg != 2'd0 |-> needed_reg != 2'd0)
        else $error("held bytes without expected continuations");

    // Held plus expected bytes never exceed a four-byte sequence.
    a_seq_len: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, held_count_reg} + {1'b0, needed_reg}) <= 3'd4)
        else $error("held sequence longer than four bytes");
`endif

endmodule

>>> rtl/jse_queue.sv
// Short job queue between the front and back parts of the escaper.
// Depends on jse_pkg.
module jse_queue
    import jse_pkg::*;
#(
    parameter int Depth = JSE_QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  jse_job_t push_job,
    input  logic     pop,
    output logic     full,
    output logic     head_valid,
    output jse_job_t head_job
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

    jse_job_t        mem_reg [0:Depth-1];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign full       = (count_reg == CntW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Job storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef ASSERT_OFF
    // The queue is neither overfilled nor drained below empty.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push |-> (!full || pop)) and (pop |-> head_valid))
        else $error("job queue overflow or underflow");
`endif

endmodule

>>> rtl/jse_back.sv
// Back part of the escaper: expands queued jobs into escaped output bytes,
// one per cycle while out_ready allows, through an output register.
// Depends on jse_pkg.
module jse_back
    import jse_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  jse_job_t   head_job,
    output logic       pop,
    input  logic       out_ready,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic [2:0] esc_done_reg, esc_done_next;
    logic [2:0] pos_reg, pos_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       advance, in_esc, final_byte;
    logic [7:0] cur_byte;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    // Pick the next byte of the current job and step the counters.
    always_comb begin
        advance = head_valid && (!out_valid_reg || out_ready);
        in_esc  = (esc_done_reg != head_job.esc_cnt);
        esc_done_next = esc_done_reg;
        pos_next      = pos_reg + 3'd1;
        if (in_esc) begin
            cur_byte   = fffd_char(pos_reg);
            final_byte = (esc_done_reg == head_job.esc_cnt - 3'd1) &&
                         (pos_reg == JSE_ESC_LAST_POS) && (head_job.tail_len == 3'd0);
            if (pos_reg == JSE_ESC_LAST_POS) begin
                pos_next      = 3'd0;
                esc_done_next = esc_done_reg + 3'd1;
            end
        end else begin
            cur_byte   = head_job.tail[pos_reg];
            final_byte = (pos_reg == head_job.tail_len - 3'd1);
        end
        if (final_byte) begin
            pos_next      = 3'd0;
            esc_done_next = 3'd0;
        end
        pop = advance && final_byte;
    end

    // Job counters and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_done_reg  <= 3'd0;
            pos_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                esc_done_reg  <= esc_done_next;
                pos_reg       <= pos_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_byte_reg <= cur_byte;
            out_last_reg <= final_byte && head_job.last;
        end
    end

`ifndef ASSERT_OFF
    // The escape counter never runs past the job's escape count.
    a_esc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> esc_done_reg <= head_job.esc_cnt)
        else $error("escape counter beyond job");
`endif

endmodule

>>> rtl/json_string_escaper.sv
// JSON string escaper with UTF-8 repair.
//
// Input channel s_*: one raw string byte per transfer, s_in_last on the final
// byte of a string. Output channel m_*: one byte of escaped text per transfer,
// m_out_last on the final output byte of a string.
// Quote and backslash are escaped, control bytes become short or \u00xx
// escapes, complete UTF-8 sequences pass unchanged, and each byte of a broken
// or unfinished sequence becomes \ufffd.
// When the block is idle, an item's first output byte passes the job queue and then
// the output register before it is presented on m_*.
// Throughput: the back part emits one output byte per cycle while m_ready allows;
// an item makes one output byte for plain ASCII and up to 24 in all.
// Bytes held in a sequence make no output.
// A queue of QueueDepth jobs parts the front from the back, so the input is
// taken while output bytes drain; s_ready drops when that queue is full.
// When the receiver stalls, the output register holds its byte and the queue
// fills, then the input stalls. Reset (aresetn low, synchronous) empties the
// queue and the output register and drops any held sequence.
// Depends on jse_pkg, jse_front, jse_queue and jse_back.
module json_string_escaper
    import jse_pkg::*;
#(
    parameter int QueueDepth = JSE_QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_last
);

    logic     accept, push, pop, full, head_valid;
    jse_job_t job, head_job;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    // Classify incoming bytes into jobs.
    jse_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_in_byte),
        .in_last (s_in_last),
        .push    (push),
        .job     (job)
    );

    // Queue of jobs between the two parts.
    jse_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Expand jobs into output bytes.
    jse_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_ready  (m_ready),
        .out_valid  (m_valid),
        .out_byte   (m_out_byte),
        .out_last   (m_out_last)
    );

endmodule
